>>> rtl/core/system_timer_64bit_compare_assert.svh
// Assertion macros for the 64-bit compare timer.
`ifndef SYSTEM_TIMER_64BIT_COMPARE_ASSERT_SVH
`define SYSTEM_TIMER_64BIT_COMPARE_ASSERT_SVH
`ifndef SYNTHESIS
`define STC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer assertion failed");
`define STC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer assertion failed");
`else
`define STC_ASSERT_IMP(lbl, ante, cons)
`define STC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/stc_pkg.sv
// Types and constants shared by the 64-bit compare timer modules.
package stc_pkg;

  localparam int unsigned PRESCALE_DIV_DEF = 8;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_CNT_LO = 3'd2;
  localparam logic [2:0] REG_CNT_HI = 3'd3;
  localparam logic [2:0] REG_CMP_LO = 3'd4;
  localparam logic [2:0] REG_CMP_HI = 3'd5;

  localparam int unsigned CTL_ENABLE = 0;
  localparam int unsigned CTL_IRQ_EN = 1;
  localparam int unsigned CTL_CLKSEL = 2;
  localparam int unsigned CTL_RELOAD = 3;
  localparam int unsigned CTL_INIT   = 5;
  localparam int unsigned CTL_W      = 6;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } op_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_nxt;
    logic        irq_cur;
  } stat_t;

endpackage

>>> rtl/core/stc_core.sv
// Timer state, register file and the per-word update logic.
module stc_core #(
  parameter int unsigned PRESCALE_DIV = stc_pkg::PRESCALE_DIV_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_fire,
  input  stc_pkg::op_t  op,
  output stc_pkg::stat_t stat
);

  localparam int unsigned PW = $clog2(PRESCALE_DIV);
  localparam logic [PW:0] DIV_W = PW'(PRESCALE_DIV - 1) + (PW+1)'(1);

  logic [stc_pkg::CTL_W-1:0] ctl_r, ctl_nxt;
  logic                      match_r, match_nxt;
  logic [63:0]               count_r, count_nxt;
  logic [63:0]               cmp_r, cmp_nxt;
  logic [PW-1:0]             pre_r, pre_nxt;

  logic [PW:0]  pre_inc;
  logic [63:0]  count_inc;
  logic         advance;
  logic [31:0]  rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      match_r <= 1'b0;
      count_r <= '0;
      cmp_r   <= '0;
      pre_r   <= '0;
    end else if (op_fire) begin
      ctl_r   <= ctl_nxt;
      match_r <= match_nxt;
      count_r <= count_nxt;
      cmp_r   <= cmp_nxt;
      pre_r   <= pre_nxt;
    end
  end

  assign pre_inc   = {1'b0, pre_r} + (PW+1)'(1);
  assign count_inc = count_r + 64'd1;

  always_comb begin
    ctl_nxt   = ctl_r;
    match_nxt = match_r;
    count_nxt = count_r;
    cmp_nxt   = cmp_r;
    pre_nxt   = pre_r;
    advance   = 1'b0;
    rd        = '0;
    case (op.mode)
      stc_pkg::MODE_TICK: begin
        if (ctl_r[stc_pkg::CTL_ENABLE]) begin
          if (ctl_r[stc_pkg::CTL_CLKSEL]) begin
            advance = 1'b1;
          end else if (pre_inc >= DIV_W) begin
            pre_nxt = '0;
            advance = 1'b1;
          end else begin
            pre_nxt = pre_inc[PW-1:0];
          end
        end
        if (advance) begin
          count_nxt = count_inc;
          // The match is checked on the advanced value only.
          if (count_inc == cmp_r) begin
            match_nxt = 1'b1;
            if (ctl_r[stc_pkg::CTL_RELOAD]) begin
              count_nxt = '0;
            end
          end
        end
      end
      stc_pkg::MODE_READ: begin
        unique case (op.reg_index)
          stc_pkg::REG_CTRL:   rd = {26'd0, ctl_r};
          stc_pkg::REG_STATUS: rd = {31'd0, match_r};
          stc_pkg::REG_CNT_LO: rd = count_r[31:0];
          stc_pkg::REG_CNT_HI: rd = count_r[63:32];
          stc_pkg::REG_CMP_LO: rd = cmp_r[31:0];
          stc_pkg::REG_CMP_HI: rd = cmp_r[63:32];
          default:             rd = '0;
        endcase
      end
      stc_pkg::MODE_WRITE: begin
        unique case (op.reg_index)
          stc_pkg::REG_CTRL: begin
            ctl_nxt = op.write_data[stc_pkg::CTL_W-1:0];
            if (op.write_data[stc_pkg::CTL_ENABLE] && op.write_data[stc_pkg::CTL_INIT]) begin
              count_nxt = '0;
            end
          end
          stc_pkg::REG_STATUS: begin
            if (op.write_data == 32'd0) begin
              match_nxt = 1'b0;
            end
          end
          stc_pkg::REG_CNT_LO: count_nxt[31:0]  = op.write_data;
          stc_pkg::REG_CNT_HI: count_nxt[63:32] = op.write_data;
          stc_pkg::REG_CMP_LO: cmp_nxt[31:0]    = op.write_data;
          stc_pkg::REG_CMP_HI: cmp_nxt[63:32]   = op.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign stat.read_data = rd;
  assign stat.irq_nxt   = match_nxt & ctl_nxt[stc_pkg::CTL_IRQ_EN];
  assign stat.irq_cur   = match_r & ctl_r[stc_pkg::CTL_IRQ_EN];

endmodule

>>> rtl/core/system_timer_64bit_compare.sv
// 64-bit system timer with compare and autoreload: accepts one tick, register read,
// register write or no-op per cycle, while in_stall is low, and returns one word for
// each. A word waits in the input register, where the 64-bit increment and compare run,
// and then in the result register, which holds it while out_stall is high. The
// interrupt bit of each result reflects the timer state after that word took effect.
`include "system_timer_64bit_compare_assert.svh"

module system_timer_64bit_compare #(
  parameter int unsigned PRESCALE_DIV = stc_pkg::PRESCALE_DIV_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq_pending
);

  logic           s1_valid_r, s1_valid_nxt;
  stc_pkg::op_t   s1_op_r;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_read_data_r;
  logic           out_irq_r;
  logic           adv, fire, in_take;
  stc_pkg::stat_t stat;

  // The input register moves on whenever the result register is free or being emptied.
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r.mode       <= stc_pkg::mode_t'(in_mode);
      s1_op_r.reg_index  <= in_reg_index;
      s1_op_r.write_data <= in_write_data;
    end
    if (fire) begin
      out_read_data_r <= stat.read_data;
      out_irq_r       <= stat.irq_nxt;
    end
  end

  stc_core #(
    .PRESCALE_DIV(PRESCALE_DIV)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .op_fire(fire),
    .op     (s1_op_r),
    .stat   (stat)
  );

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_read_data_r;
  assign out_irq_pending = out_irq_r;

  `STC_ASSERT_IMP(a_stall_only_full, in_stall, s1_valid_r)
  `STC_ASSERT_NXT(a_fire_loads_out, fire, out_valid_r)
  // Timer state only changes when a word is loaded into the result register.
  `STC_ASSERT_IMP(a_irq_tracks_state, out_valid_r, out_irq_r == stat.irq_cur)
  `STC_ASSERT_NXT(a_held_word_stays, out_valid_r && out_stall && !fire, out_valid_r)

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the 64-bit compare timer: directed tests, then random traffic.
module tb_top;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } timer_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = stc_pkg::MODE_NOP;
  logic [2:0]  in_reg_index = stc_pkg::REG_CTRL;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_irq_pending;

  // Timer state as the testbench expects it to be after every accepted word.
  logic [stc_pkg::CTL_W-1:0] timer_ctrl = '0;
  logic                      match_seen = 1'b0;
  logic [63:0]               timer_count = '0;
  logic [63:0]               timer_compare = '0;
  logic [2:0]                prescale_phase = '0;

  timer_word_t expected_words[$];
  timer_word_t oldest_word;
  int          mismatches = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  bit          gapless = 1'b0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          hold_left = 0;
  int          stall_run = 0;
  bit          stall_on = 1'b0;

  system_timer_64bit_compare dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_reg_index   (in_reg_index),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_irq_pending(out_irq_pending)
  );

  always #10 clk = ~clk;

  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 2);
    if (pick < 94) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < 100)
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
    mismatches = mismatches + 1;
  endtask

  task automatic bump_count();
    timer_count = timer_count + 64'd1;
    if (timer_count == timer_compare) begin
      match_seen = 1'b1;
      if (timer_ctrl[stc_pkg::CTL_RELOAD]) timer_count = '0;
    end
  endtask

  // Applies one accepted word to the expected timer state and returns its result.
  task automatic timer_predict(input stc_pkg::mode_t m, input logic [2:0] r,
                               input logic [31:0] d, output timer_word_t res);
    res.read_data = '0;
    case (m)
      stc_pkg::MODE_TICK: begin
        if (timer_ctrl[stc_pkg::CTL_ENABLE]) begin
          if (timer_ctrl[stc_pkg::CTL_CLKSEL]) begin
            bump_count();
          end else if ({29'd0, prescale_phase} + 32'd1 >= stc_pkg::PRESCALE_DIV_DEF) begin
            prescale_phase = '0;
            bump_count();
          end else begin
            prescale_phase = prescale_phase + 3'd1;
          end
        end
      end
      stc_pkg::MODE_READ: begin
        case (r)
          stc_pkg::REG_CTRL:   res.read_data = {{(32 - stc_pkg::CTL_W){1'b0}}, timer_ctrl};
          stc_pkg::REG_STATUS: res.read_data = {31'd0, match_seen};
          stc_pkg::REG_CNT_LO: res.read_data = timer_count[31:0];
          stc_pkg::REG_CNT_HI: res.read_data = timer_count[63:32];
          stc_pkg::REG_CMP_LO: res.read_data = timer_compare[31:0];
          stc_pkg::REG_CMP_HI: res.read_data = timer_compare[63:32];
          default:             res.read_data = '0;
        endcase
      end
      stc_pkg::MODE_WRITE: begin
        case (r)
          stc_pkg::REG_CTRL: begin
            timer_ctrl = d[stc_pkg::CTL_W-1:0];
            if (d[stc_pkg::CTL_ENABLE] && d[stc_pkg::CTL_INIT]) timer_count = '0;
          end
          stc_pkg::REG_STATUS: if (d == 32'd0) match_seen = 1'b0;
          stc_pkg::REG_CNT_LO: timer_count[31:0] = d;
          stc_pkg::REG_CNT_HI: timer_count[63:32] = d;
          stc_pkg::REG_CMP_LO: timer_compare[31:0] = d;
          stc_pkg::REG_CMP_HI: timer_compare[63:32] = d;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.irq = match_seen & timer_ctrl[stc_pkg::CTL_IRQ_EN];
  endtask

  // Offers one word after a random gap (none in gapless or burst mode) and predicts its result once it is taken.
  task automatic send_word(input stc_pkg::mode_t m, input logic [2:0] r,
                           input logic [31:0] d);
    int gap;
    timer_word_t want;
    if (gapless) begin
      gap = 0;
    end else if (burst_left > 0) begin
      burst_left = burst_left - 1;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_reg_index  <= r;
    in_write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    timer_predict(m, r, d, want);
    expected_words.push_back(want);
    if (m != stc_pkg::MODE_NOP) words_sent = words_sent + 1;
  endtask

  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_on = !stall_on;
        stall_run = stall_on ? 1 + idle_len() : $urandom_range(1, 40);
      end
      stall_run = stall_run - 1;
      out_stall <= stall_on;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, read_data", '0, out_read_data);
      end else begin
        oldest_word = expected_words.pop_front();
        if (out_read_data !== oldest_word.read_data)
          report_mismatch("read_data", oldest_word.read_data, out_read_data);
        if (out_irq_pending !== oldest_word.irq)
          report_mismatch("irq_pending", {31'd0, oldest_word.irq}, {31'd0, out_irq_pending});
      end
    end
  end

  task automatic test_reset_values();
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_CTRL, 32'hFFFF_FFFF);
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_CMP_HI, 32'd0);
  endtask

  // The counter wraps from all ones to zero and meets a compare value of zero.
  task automatic test_wrap_and_match();
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CNT_LO, 32'hFFFF_FFFF);
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CNT_HI, 32'hFFFF_FFFF);
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_CNT_HI, 32'd0);
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CTRL, 32'hFFFF_FFC7);
    send_word(stc_pkg::MODE_TICK, stc_pkg::REG_CTRL, 32'd0);
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_STATUS, 32'd0);
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_CNT_HI, 32'd0);
  endtask

  task automatic test_status_clear();
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_STATUS, 32'd2);
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_STATUS, 32'd0);
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_STATUS, 32'd0);
  endtask

  task automatic test_autoreload();
    logic [31:0] ctl;
    ctl = '0;
    ctl[stc_pkg::CTL_ENABLE] = 1'b1;
    ctl[stc_pkg::CTL_IRQ_EN] = 1'b1;
    ctl[stc_pkg::CTL_CLKSEL] = 1'b1;
    ctl[stc_pkg::CTL_RELOAD] = 1'b1;
    ctl[stc_pkg::CTL_INIT]   = 1'b1;
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CMP_LO, 32'd3);
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CTRL, ctl);
    repeat (3) send_word(stc_pkg::MODE_TICK, 3'd7, 32'hFFFF_FFFF);
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_CNT_LO, 32'd0);
  endtask

  task automatic test_unknown_access();
    send_word(stc_pkg::MODE_WRITE, 3'd6, 32'hFFFF_FFFF);
    send_word(stc_pkg::MODE_READ, 3'd7, 32'd0);
    send_word(stc_pkg::MODE_NOP, 3'd7, 32'hFFFF_FFFF);
  endtask

  // Init without enable must leave the counter alone, and ticks must do nothing.
  task automatic test_disabled_ticks();
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CTRL, 32'h0000_0030);
    send_word(stc_pkg::MODE_TICK, stc_pkg::REG_CTRL, 32'd0);
    send_word(stc_pkg::MODE_READ, stc_pkg::REG_CNT_LO, 32'd0);
  endtask

  // Places the compare value 1 to 12 counts ahead of the counter; sends enough ticks to reach it if enabled.
  task automatic run_to_match();
    logic [31:0] ctl;
    logic [63:0] goal;
    int step_gap;
    int ticks;
    ctl = $urandom();
    ctl[stc_pkg::CTL_ENABLE] = ($urandom_range(0, 9) != 0);
    ctl[stc_pkg::CTL_IRQ_EN] = 1'($urandom_range(0, 1));
    ctl[stc_pkg::CTL_CLKSEL] = ($urandom_range(0, 3) != 0);
    ctl[stc_pkg::CTL_RELOAD] = 1'($urandom_range(0, 1));
    ctl[stc_pkg::CTL_INIT]   = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 6) == 0) begin
      send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CNT_HI, 32'hFFFF_FFFF);
      send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CNT_LO,
                32'hFFFF_FFFF - $urandom_range(0, 12));
    end
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CTRL, ctl);
    step_gap = $urandom_range(1, 12);
    goal = timer_count + 64'(step_gap);
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CMP_HI, goal[63:32]);
    send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_CMP_LO, goal[31:0]);
    ticks = (ctl[stc_pkg::CTL_CLKSEL] ? step_gap : step_gap * stc_pkg::PRESCALE_DIV_DEF)
            + $urandom_range(0, 6);
    repeat (ticks) begin
      if ($urandom_range(0, 4) == 0)
        send_word(stc_pkg::MODE_READ, 3'($urandom_range(0, 7)), $urandom());
      send_word(stc_pkg::MODE_TICK, 3'($urandom_range(0, 7)), $urandom());
    end
    if ($urandom_range(0, 1) == 1)
      send_word(stc_pkg::MODE_WRITE, stc_pkg::REG_STATUS,
                ($urandom_range(0, 2) == 0) ? $urandom() : 32'd0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 16))
      send_word(stc_pkg::mode_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom());
  endtask

  task automatic test_random_traffic();
    int goal_words;
    goal_words = words_sent + 1500;
    while (words_sent < goal_words) begin
      if ($urandom_range(0, 9) < 6) run_to_match();
      else send_noise();
    end
  endtask

  // The result side holds off for a long stretch while words keep coming.
  task automatic test_output_backpressure();
    hold_asked <= hold_asked + 1;
    gapless = 1'b1;
    repeat (30)
      send_word(stc_pkg::mode_t'($urandom_range(0, 2)), 3'($urandom_range(0, 7)), $urandom());
    gapless = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_wrap_and_match();
    test_status_clear();
    test_autoreload();
    test_unknown_access();
    test_disabled_ticks();
    test_output_backpressure();
    test_random_traffic();
    test_output_backpressure();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/stc_pkg.sv
rtl/core/stc_core.sv
rtl/core/system_timer_64bit_compare.sv
dv/tb_top.sv
